### hw/rtl/rttu_pkg.sv
// ----------------------------------------------------------------------------
// rttu_pkg
// Shared constants, types and the character-to-digit function of the radix
// text to unsigned parser.
// ----------------------------------------------------------------------------
package rttu_pkg;

    localparam longint unsigned RTTU_MAX_LENGTH = 64'd65535;

    localparam int RTTU_CH_W     = 8;
    localparam int RTTU_BASE_W   = 6;
    localparam int RTTU_VALUE_W  = 64;
    localparam int RTTU_OFFSET_W = 16;

    typedef logic [RTTU_CH_W-1:0]     t_char;
    typedef logic [RTTU_BASE_W-1:0]   t_base;
    typedef logic [RTTU_VALUE_W-1:0]  t_value;
    typedef logic [RTTU_OFFSET_W-1:0] t_offset;

    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_UP_A  = 8'h41;
    localparam t_char CH_UP_B  = 8'h42;
    localparam t_char CH_UP_X  = 8'h58;
    localparam t_char CH_UP_Z  = 8'h5A;
    localparam t_char CH_LO_A  = 8'h61;
    localparam t_char CH_LO_B  = 8'h62;
    localparam t_char CH_LO_X  = 8'h78;
    localparam t_char CH_LO_Z  = 8'h7A;

    localparam t_base BASE_AUTO = 6'd0;
    localparam t_base BASE_BIN  = 6'd2;
    localparam t_base BASE_OCT  = 6'd8;
    localparam t_base BASE_DEC  = 6'd10;
    localparam t_base BASE_HEX  = 6'd16;
    localparam t_base BASE_MAX  = 6'd36;

    localparam t_offset OFFSET_MAX = 16'hFFFF;

    // 36 marks a byte that is no digit in any base
    function automatic t_base digit_of(input t_char c);
        t_base d;
        d = BASE_MAX;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = RTTU_BASE_W'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = RTTU_BASE_W'(c - CH_LO_A) + BASE_DEC;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = RTTU_BASE_W'(c - CH_UP_A) + BASE_DEC;
        end
        return d;
    endfunction

endpackage

### hw/rtl/radix_text_to_unsigned_parser.sv
// ----------------------------------------------------------------------------
// radix_text_to_unsigned_parser
// Streaming text-to-unsigned conversion: white space, sign, base prefix and
// digits up to base 36, with saturation on overflow.
// ----------------------------------------------------------------------------
// The parser takes one character word per cycle with no gaps and gives one
// result word per string from the result register: the word marked last
// sits in the input register for the cycle while the character decode
// and the accumulator multiply-add (64 by 6 bits) feed the result register.
// That multiply-add with its overflow test is the only path that spans the
// cycle. Input only stalls when a last word meets a result that has not been
// taken. The radix register is sampled at the first character that is not
// white space; write it only between strings. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module radix_text_to_unsigned_parser
    import rttu_pkg::*;
#(
    parameter longint unsigned MAX_LENGTH = RTTU_MAX_LENGTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [5:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_ch,
    input  logic          i_last,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [63:0]   o_value,
    output logic [15:0]   o_end_offset,
    output logic          o_overflow,
    output logic          o_no_digits
);

    localparam int PW = $clog2(MAX_LENGTH + 64'd1);
    localparam int OW = (PW > RTTU_OFFSET_W) ? PW : RTTU_OFFSET_W;
    localparam int MW = RTTU_VALUE_W + RTTU_BASE_W;
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_LENGTH);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    t_base          r_radix;

    logic           r_in_valid;
    t_char          r_ch;
    logic           r_last;

    logic [2:0]     r_phase, n_phase;
    logic           r_neg, n_neg;
    t_value         r_acc, n_acc;
    t_base          r_base, n_base;
    logic [PW-1:0]  r_pos;
    logic [PW-1:0]  r_mark, n_mark;
    logic           r_sat, n_sat;

    logic           r_out_valid;
    t_value         r_out_acc;
    logic           r_out_neg;
    t_offset        r_out_off;
    logic           r_out_sat;
    logic           r_out_none;

    logic           proc_go;
    logic           is_space;
    t_base          dig;
    t_base          lr;
    t_base          fp_base, fp_base10;
    t_base          dig_base;
    logic [MW-1:0]  prod;
    logic           fits;
    logic           do_digit;
    logic [PW-1:0]  after;
    logic [OW-1:0]  mark_ext;
    t_offset        off;

    assign proc_go    = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_go;

    assign is_space = (r_ch == CH_SPACE) || (r_ch >= CH_TAB && r_ch <= CH_CR);
    assign dig      = digit_of(r_ch);
    assign after    = (r_pos < MAX_POS) ? r_pos + PW'(1) : MAX_POS;

    always_comb begin
        if (r_radix == BASE_AUTO) begin
            lr = BASE_AUTO;
        end else if (r_radix < BASE_BIN) begin
            lr = BASE_BIN;
        end else if (r_radix > BASE_MAX) begin
            lr = BASE_MAX;
        end else begin
            lr = r_radix;
        end
    end

    assign fp_base   = (r_phase == PH_SPACE) ? lr : r_base;
    assign fp_base10 = (fp_base == BASE_AUTO) ? BASE_DEC : fp_base;
    assign dig_base  = (r_phase == PH_ZERO && r_base == BASE_AUTO) ? BASE_OCT : r_base;

    assign prod = MW'(r_acc) * MW'(dig_base) + MW'(dig);
    assign fits = (prod[MW-1:RTTU_VALUE_W] == '0);

    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_base   = r_base;
        n_mark   = r_mark;
        n_sat    = r_sat;
        do_digit = 1'b0;
        unique case (r_phase)
            PH_SPACE, PH_FIRST: begin
                if (r_phase == PH_FIRST || !is_space) begin
                    n_base = fp_base;
                    if (r_phase == PH_SPACE && (r_ch == CH_MINUS || r_ch == CH_PLUS)) begin
                        n_neg   = (r_ch == CH_MINUS);
                        n_phase = PH_FIRST;
                    end else if (r_ch == CH_ZERO) begin
                        n_acc  = '0;
                        n_mark = after;
                        if (fp_base == BASE_AUTO || fp_base == BASE_HEX ||
                            fp_base == BASE_BIN) begin
                            n_phase = PH_ZERO;
                        end else begin
                            n_phase = PH_DIGITS;
                        end
                    end else begin
                        n_base = fp_base10;
                        if (dig < fp_base10) begin
                            n_acc   = RTTU_VALUE_W'(dig);
                            n_mark  = after;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
            PH_ZERO: begin
                if ((r_ch == CH_LO_X || r_ch == CH_UP_X) &&
                    (r_base == BASE_AUTO || r_base == BASE_HEX)) begin
                    n_base  = BASE_HEX;
                    n_phase = PH_PREFIX;
                end else if ((r_ch == CH_LO_B || r_ch == CH_UP_B) &&
                             (r_base == BASE_AUTO || r_base == BASE_BIN)) begin
                    n_base  = BASE_BIN;
                    n_phase = PH_PREFIX;
                end else begin
                    n_base   = dig_base;
                    n_phase  = PH_DIGITS;
                    do_digit = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (dig < r_base) begin
                    n_phase  = PH_DIGITS;
                    do_digit = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
            end
        endcase
        if (do_digit) begin
            if (dig >= dig_base) begin
                n_phase = PH_DONE;
            end else begin
                if (!r_sat) begin
                    if (fits) begin
                        n_acc = prod[RTTU_VALUE_W-1:0];
                    end else begin
                        n_sat = 1'b1;
                    end
                end
                n_mark = after;
            end
        end
    end

    assign mark_ext = OW'(n_mark);
    assign off      = (mark_ext > OW'(OFFSET_MAX)) ? OFFSET_MAX
                                                   : mark_ext[RTTU_OFFSET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= BASE_AUTO;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_base  <= BASE_AUTO;
            r_pos   <= '0;
            r_mark  <= '0;
            r_sat   <= 1'b0;
        end else if (proc_go) begin
            if (r_last) begin
                r_phase <= PH_SPACE;
                r_neg   <= 1'b0;
                r_acc   <= '0;
                r_base  <= BASE_AUTO;
                r_pos   <= '0;
                r_mark  <= '0;
                r_sat   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_base  <= n_base;
                r_pos   <= after;
                r_mark  <= n_mark;
                r_sat   <= n_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && r_last) begin
            r_out_none <= (n_mark == '0);
            r_out_sat  <= (n_mark != '0) && n_sat;
            r_out_neg  <= n_neg;
            r_out_acc  <= (n_mark == '0) ? '0 : n_acc;
            r_out_off  <= (n_mark == '0) ? '0 : off;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_out_sat ? '1 : (r_out_neg ? '0 - r_out_acc : r_out_acc);
    assign o_end_offset = r_out_off;
    assign o_overflow   = r_out_sat;
    assign o_no_digits  = r_out_none;

    a_no_digits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_digits |-> o_value == '0 && o_end_offset == '0 && !o_overflow)
        else $error("no-digit result carries a value");

    a_overflow_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_value == '1 && !o_no_digits)
        else $error("saturated result is not all ones");

    a_offset_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_no_digits |-> o_end_offset != '0)
        else $error("digits found but no characters consumed");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && r_last |=> r_phase == PH_SPACE && r_mark == '0 && r_pos == '0 && !r_sat)
        else $error("parser state not cleared after end of string");

endmodule
